FILE: rtl/nte_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nte_pkg: shared types, word codes and control program
// Word code constants, the decimal digit vector type and the read-only
// control store that drives the word sequencer.
// ----------------------------------------------------------------------------
package nte_pkg;

  // Input and output field widths.
  localparam int VALUE_W   = 31;
  localparam int CODE_W    = 5;
  localparam int NUM_DIGITS = 10;

  // Word codes that the sequencer produces by name.
  localparam logic [CODE_W-1:0] WORD_ZERO     = 5'd0;
  localparam logic [CODE_W-1:0] WORD_TEN      = 5'd10;
  localparam logic [CODE_W-1:0] TENS_BASE     = 5'd18;
  localparam logic [CODE_W-1:0] WORD_HUNDRED  = 5'd28;
  localparam logic [CODE_W-1:0] WORD_THOUSAND = 5'd29;
  localparam logic [CODE_W-1:0] WORD_MILLION  = 5'd30;
  localparam logic [CODE_W-1:0] WORD_BILLION  = 5'd31;

  // Ten BCD digits, index 0 is the ones digit.
  typedef logic [NUM_DIGITS-1:0][3:0] digits_t;

  // Control store geometry.
  localparam int PROG_LEN = 26;
  localparam int PC_W     = $clog2(PROG_LEN);
  typedef logic [PC_W-1:0] pc_t;

  // Word source selected by a control word.
  typedef enum logic [2:0] {
    SEL_NONE,
    SEL_ZERO,
    SEL_HDIG,
    SEL_HUNDRED,
    SEL_TENS,
    SEL_ONES,
    SEL_SCALE
  } sel_t;

  // Condition tested by a control word.
  typedef enum logic [2:0] {
    C_ALWAYS,
    C_VAL_NZ,
    C_GRP_Z,
    C_H_NZ,
    C_TENS,
    C_ONES
  } cond_t;

  // One control word: when the condition holds, a word is emitted and/or
  // the step counter jumps; fin ends the program after this step.
  typedef struct packed {
    sel_t       sel;
    cond_t      cond;
    logic       emit;
    logic       jump;
    pc_t        target;
    logic [1:0] grp;
    logic       fin;
  } ctrl_t;

  function automatic ctrl_t cw(sel_t sel, cond_t cond, logic emit, logic jump,
                               pc_t target, logic [1:0] grp, logic fin);
    ctrl_t w;
    w.sel    = sel;
    w.cond   = cond;
    w.emit   = emit;
    w.jump   = jump;
    w.target = target;
    w.grp    = grp;
    w.fin    = fin;
    return w;
  endfunction

  // The spelling program. Groups are billions, millions, thousands, units.
  // Each group opens with a skip over the whole group when it is zero.
  function automatic ctrl_t nte_prog(pc_t pc);
    ctrl_t w;
    unique case (pc)
      // Zero is the only input that spells as the single word Zero.
      5'd0:  w = cw(SEL_NONE,    C_VAL_NZ, 1'b0, 1'b1, 5'd2,  2'd0, 1'b0);
      5'd1:  w = cw(SEL_ZERO,    C_ALWAYS, 1'b1, 1'b0, 5'd0,  2'd0, 1'b1);
      // Billions group.
      5'd2:  w = cw(SEL_NONE,    C_GRP_Z,  1'b0, 1'b1, 5'd8,  2'd0, 1'b0);
      5'd3:  w = cw(SEL_HDIG,    C_H_NZ,   1'b1, 1'b0, 5'd0,  2'd0, 1'b0);
      5'd4:  w = cw(SEL_HUNDRED, C_H_NZ,   1'b1, 1'b0, 5'd0,  2'd0, 1'b0);
      5'd5:  w = cw(SEL_TENS,    C_TENS,   1'b1, 1'b0, 5'd0,  2'd0, 1'b0);
      5'd6:  w = cw(SEL_ONES,    C_ONES,   1'b1, 1'b0, 5'd0,  2'd0, 1'b0);
      5'd7:  w = cw(SEL_SCALE,   C_ALWAYS, 1'b1, 1'b0, 5'd0,  2'd0, 1'b0);
      // Millions group.
      5'd8:  w = cw(SEL_NONE,    C_GRP_Z,  1'b0, 1'b1, 5'd14, 2'd1, 1'b0);
      5'd9:  w = cw(SEL_HDIG,    C_H_NZ,   1'b1, 1'b0, 5'd0,  2'd1, 1'b0);
      5'd10: w = cw(SEL_HUNDRED, C_H_NZ,   1'b1, 1'b0, 5'd0,  2'd1, 1'b0);
      5'd11: w = cw(SEL_TENS,    C_TENS,   1'b1, 1'b0, 5'd0,  2'd1, 1'b0);
      5'd12: w = cw(SEL_ONES,    C_ONES,   1'b1, 1'b0, 5'd0,  2'd1, 1'b0);
      5'd13: w = cw(SEL_SCALE,   C_ALWAYS, 1'b1, 1'b0, 5'd0,  2'd1, 1'b0);
      // Thousands group.
      5'd14: w = cw(SEL_NONE,    C_GRP_Z,  1'b0, 1'b1, 5'd20, 2'd2, 1'b0);
      5'd15: w = cw(SEL_HDIG,    C_H_NZ,   1'b1, 1'b0, 5'd0,  2'd2, 1'b0);
      5'd16: w = cw(SEL_HUNDRED, C_H_NZ,   1'b1, 1'b0, 5'd0,  2'd2, 1'b0);
      5'd17: w = cw(SEL_TENS,    C_TENS,   1'b1, 1'b0, 5'd0,  2'd2, 1'b0);
      5'd18: w = cw(SEL_ONES,    C_ONES,   1'b1, 1'b0, 5'd0,  2'd2, 1'b0);
      5'd19: w = cw(SEL_SCALE,   C_ALWAYS, 1'b1, 1'b0, 5'd0,  2'd2, 1'b0);
      // Units group, which has no scale word.
      5'd20: w = cw(SEL_NONE,    C_GRP_Z,  1'b0, 1'b1, 5'd25, 2'd3, 1'b0);
      5'd21: w = cw(SEL_HDIG,    C_H_NZ,   1'b1, 1'b0, 5'd0,  2'd3, 1'b0);
      5'd22: w = cw(SEL_HUNDRED, C_H_NZ,   1'b1, 1'b0, 5'd0,  2'd3, 1'b0);
      5'd23: w = cw(SEL_TENS,    C_TENS,   1'b1, 1'b0, 5'd0,  2'd3, 1'b0);
      5'd24: w = cw(SEL_ONES,    C_ONES,   1'b1, 1'b0, 5'd0,  2'd3, 1'b0);
      // End of program; unused addresses also end it.
      default: w = cw(SEL_NONE,  C_ALWAYS, 1'b0, 1'b0, 5'd0,  2'd3, 1'b1);
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/number_to_english_word_codes.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// number_to_english_word_codes: spell an integer as English word codes
// Converts a 31-bit value to decimal, then runs a small control program
// that emits the words of its English spelling, most significant first.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: value with in_valid / in_stall. A transfer is taken only
//   while the block is idle; in_stall is high from the transfer until the
//   last word of that number has moved into the output register.
//   Output channel: word_code and last_word with out_valid / out_stall. Each
//   word is one transfer; last_word marks the final word of a number.
//   Sequence: the serial decimal conversion runs first, then the control
//   program steps once per cycle unless it waits on the output, 2 to 25
//   steps, and a flush state hands over the final word. A new number is
//   taken only once the final word of the last one has moved into the
//   output register.
//   One word is held back in a pending register so that the final word can
//   be marked; a stalled receiver holds the output register and the program
//   waits whenever it must emit while both the output and the pending word
//   are full.
//   Reset: synchronous, active high; clears the sequencer to idle and drops
//   out_valid. Words in flight are discarded.
// ----------------------------------------------------------------------------
module number_to_english_word_codes (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [nte_pkg::VALUE_W-1:0]   value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [nte_pkg::CODE_W-1:0]    word_code,
  output logic                          last_word
);
  import nte_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_RUN,
    ST_FLUSH
  } state_t;

  state_t            state;
  pc_t               pc;
  pc_t               pc_next;
  logic              pend_valid;
  logic [CODE_W-1:0] pend_code;

  logic              accept;
  logic              bcd_done;
  digits_t           digits;

  ctrl_t             ctrl;
  logic [3:0]        h;
  logic [3:0]        t;
  logic [3:0]        o;
  logic              cond_ok;
  logic [CODE_W-1:0] word;
  logic              do_emit;
  logic              out_free;
  logic              step_ok;
  logic              out_load;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && (state == ST_IDLE);
  assign out_free = !out_valid || !out_stall;

  // Decimal conversion unit.
  nte_bcd u_bcd (
    .clk    (clk),
    .rst    (rst),
    .start  (accept),
    .value  (value),
    .done   (bcd_done),
    .digits (digits)
  );

  // Fetch the control word and select the digits of its group.
  always_comb begin
    ctrl = nte_prog(pc);
    unique case (ctrl.grp)
      2'd0: begin
        h = 4'd0;
        t = 4'd0;
        o = digits[9];
      end
      2'd1: begin
        h = digits[8];
        t = digits[7];
        o = digits[6];
      end
      2'd2: begin
        h = digits[5];
        t = digits[4];
        o = digits[3];
      end
      default: begin
        h = digits[2];
        t = digits[1];
        o = digits[0];
      end
    endcase
  end

  // Evaluate the step condition.
  always_comb begin
    unique case (ctrl.cond)
      C_ALWAYS: cond_ok = 1'b1;
      C_VAL_NZ: cond_ok = |digits;
      C_GRP_Z:  cond_ok = (h == 4'd0) && (t == 4'd0) && (o == 4'd0);
      C_H_NZ:   cond_ok = (h != 4'd0);
      C_TENS:   cond_ok = (t >= 4'd2);
      C_ONES:   cond_ok = (t >= 4'd2) ? (o != 4'd0) : ((t != 4'd0) || (o != 4'd0));
      default:  cond_ok = 1'b0;
    endcase
  end

  // Build the word that this step emits.
  always_comb begin
    unique case (ctrl.sel)
      SEL_ZERO:    word = WORD_ZERO;
      SEL_HDIG:    word = {1'b0, h};
      SEL_HUNDRED: word = WORD_HUNDRED;
      SEL_TENS:    word = TENS_BASE + {1'b0, t};
      // Below twenty the tens digit is zero or one: a ones or a teen word.
      SEL_ONES:    word = (t >= 4'd2) ? {1'b0, o} :
                          ((t != 4'd0) ? WORD_TEN + {1'b0, o} : {1'b0, o});
      SEL_SCALE: begin
        unique case (ctrl.grp)
          2'd0:    word = WORD_BILLION;
          2'd1:    word = WORD_MILLION;
          2'd2:    word = WORD_THOUSAND;
          default: word = WORD_ZERO;
        endcase
      end
      default:     word = WORD_ZERO;
    endcase
  end

  // A step waits only when it must push the pending word into a full output.
  // The output register loads when a step pushes the pending word out, or
  // when the final word is handed over.
  always_comb begin
    do_emit  = cond_ok && ctrl.emit;
    step_ok  = !do_emit || !pend_valid || out_free;
    pc_next  = (cond_ok && ctrl.jump) ? ctrl.target : pc + 1'b1;
    out_load = ((state == ST_RUN) && step_ok && do_emit && pend_valid) ||
               ((state == ST_FLUSH) && out_free);
  end

  // Sequencer state, pending word and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      pc         <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
        word_code <= pend_code;
        last_word <= (state == ST_FLUSH);
      end else if (out_free) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_CONV;
          end
        end
        ST_CONV: begin
          if (bcd_done) begin
            state <= ST_RUN;
            pc    <= '0;
          end
        end
        ST_RUN: begin
          if (step_ok) begin
            if (do_emit) begin
              pend_valid <= 1'b1;
              pend_code  <= word;
            end
            pc <= pc_next;
            if (ctrl.fin) begin
              state <= ST_FLUSH;
            end
          end
        end
        ST_FLUSH: begin
          if (out_free) begin
            pend_valid <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/nte_bcd.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nte_bcd: serial binary to BCD converter
// Shift-and-add-3 conversion, one input bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module nte_bcd (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [nte_pkg::VALUE_W-1:0]   value,
  output logic                          done,
  output nte_pkg::digits_t              digits
);
  import nte_pkg::*;

  localparam int CNT_W = $clog2(VALUE_W);

  logic [VALUE_W-1:0] sh;
  logic [CNT_W-1:0]   cnt;
  logic               run;
  digits_t            adj;
  logic [4*NUM_DIGITS:0] cat;

  // Add three to every digit of five or more before the shift.
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      adj[i] = (digits[i] >= 4'd5) ? digits[i] + 4'd3 : digits[i];
    end
    cat = {adj, sh[VALUE_W-1]};
  end

  // Shift register, digit register and bit counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      run    <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
      digits <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run    <= 1'b1;
        cnt    <= '0;
        sh     <= value;
        digits <= '0;
      end else if (run) begin
        digits <= digits_t'(cat[4*NUM_DIGITS-1:0]);
        sh     <= {sh[VALUE_W-2:0], 1'b0};
        cnt    <= cnt + 1'b1;
        if (cnt == CNT_W'(VALUE_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
